FILE: rtl/core/ctcd_pkg.sv
// shared types and constants of the ctc greedy decoder
// holds the exponential table, the row record, register indexes and result kinds
package ctcd_pkg;

  localparam int MaxClasses   = 8192;
  localparam int MaxTimeSteps = 4096;
  localparam int ExpDepth     = 256;
  localparam int ExpIdxW      = $clog2(ExpDepth);

  localparam logic [16:0] OneQ16    = 17'd65536;
  localparam logic [16:0] Log2eQ16  = 17'd94548;
  localparam logic [31:0] Ln2Q32    = 32'd2977044472;
  localparam logic [29:0] TotalMax  = 30'h3FFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] RegClassCount = 2'd0;
  localparam logic [1:0] RegBlank      = 2'd1;
  localparam logic [1:0] RegProbMode   = 2'd2;
  localparam logic [1:0] RegDictSize   = 2'd3;

  // result kinds
  localparam logic KindSymbol = 1'b0;
  localparam logic KindMean   = 1'b1;

  // one finished row handed from the front to the back
  typedef struct packed {
    logic [12:0]        best;
    logic signed [15:0] maxv;
    logic [31:0]        sum;
    logic               eos;
  } row_t;

  typedef logic [16:0] exp_tbl_t [ExpDepth];

  // 2^(-i/ExpDepth) in q1.16, series evaluation of exp(-i*ln2/ExpDepth)
  function automatic exp_tbl_t build_exp_table();
    exp_tbl_t           t;
    logic [63:0]        z;
    logic [63:0]        term;
    logic signed [65:0] acc;
    logic [65:0]        rnd;
    for (int i = 0; i < ExpDepth; i++) begin
      z    = (64'(i) * 64'(Ln2Q32)) / ExpDepth;
      term = 64'd1 << 32;
      acc  = 66'sd1 <<< 32;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * z) >> 32) / 64'(n);
        if (n % 2 == 1) begin
          acc = acc - $signed({2'b00, term});
        end else begin
          acc = acc + $signed({2'b00, term});
        end
      end
      rnd  = (66'(acc) + 66'd32768) >> 16;
      t[i] = rnd[16:0];
    end
    return t;
  endfunction

  localparam exp_tbl_t ExpTable = build_exp_table();

endpackage

FILE: rtl/core/ctcd_fifo.sv
// two-entry queue of finished rows between front and back
// depends on ctcd_pkg for the row record
module ctcd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  ctcd_pkg::row_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output ctcd_pkg::row_t rd_data_o,
  output logic           rd_valid_o
);
  import ctcd_pkg::*;

  row_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(wr_en_i) - 2'(rd_en_i);
    end
  end

  assign full_o     = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/ctcd_front.sv
// front: takes scores, tracks the row maximum and the rescaled exp sum
// depends on ctcd_pkg for the exp table and the row record
module ctcd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [15:0]    in_score_i,
  input  logic           in_eos_i,
  input  logic [13:0]    class_count_i,
  output logic           push_o,
  output ctcd_pkg::row_t push_data_o,
  input  logic           full_i
);
  import ctcd_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_LOOK, F_SCALE, F_UPD, F_PUSH} fstate_e;
  typedef enum logic [1:0] {M_FIRST, M_NEWMAX, M_ADD} mode_e;

  fstate_e            state_q;
  mode_e              mode_q;
  logic [12:0]        pos_q;
  logic signed [15:0] max_q;
  logic signed [15:0] sv_q;
  logic [12:0]        best_q;
  logic [31:0]        sum_q;
  logic               eos_q;
  logic [15:0]        d_q;
  logic [32:0]        e_q;
  logic [16:0]        f_q;
  logic [48:0]        prod_q;
  row_t               rec_q;

  logic signed [15:0] sv;
  logic [16:0]        diff;
  logic [13:0]        len;
  logic [32:0]        rnd;
  logic [33:0]        scaled;
  logic [32:0]        added;
  logic [31:0]        sum_n;
  logic               row_end;

  assign sv = $signed(in_score_i);

  always_comb begin
    if (class_count_i == 14'd0)       len = 14'd1;
    else if (class_count_i > 14'(MaxClasses)) len = 14'(MaxClasses);
    else                              len = class_count_i;
  end

  always_comb begin
    if (sv > max_q) diff = 17'($signed(sv) - $signed(max_q));
    else            diff = 17'($signed(max_q) - $signed(sv));
  end

  // start at one on a row's first score, rescale on a new maximum, plain saturating add otherwise
  always_comb begin
    rnd    = 33'((prod_q + 49'd32768) >> 16);
    scaled = {1'b0, rnd} + 34'(OneQ16);
    added  = {1'b0, sum_q} + 33'(f_q);
    case (mode_q)
      M_FIRST:  sum_n = 32'(OneQ16);
      M_NEWMAX: sum_n = (scaled > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
      M_ADD:    sum_n = added[32] ? 32'hFFFF_FFFF : added[31:0];
      default:  sum_n = sum_q;
    endcase
    row_end = eos_q || ({1'b0, pos_q} + 14'd1 >= len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mode_q  <= M_FIRST;
      pos_q   <= '0;
      max_q   <= '0;
      best_q  <= '0;
      sum_q   <= '0;
      sv_q    <= '0;
      eos_q   <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            sv_q  <= sv;
            eos_q <= in_eos_i;
            d_q   <= diff[15:0];
            if (pos_q == 13'd0) mode_q <= M_FIRST;
            else if (sv > max_q) mode_q <= M_NEWMAX;
            else mode_q <= M_ADD;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          e_q     <= 33'(d_q) * 33'(Log2eQ16);
          state_q <= F_LOOK;
        end
        F_LOOK: begin
          // integer part of the exponent shifts the table entry
          f_q     <= ExpTable[e_q[27:28-ExpIdxW]] >> e_q[32:28];
          state_q <= F_SCALE;
        end
        F_SCALE: begin
          prod_q  <= 49'(sum_q) * 49'(f_q);
          state_q <= F_UPD;
        end
        F_UPD: begin
          sum_q <= sum_n;
          if (mode_q != M_ADD) max_q <= sv_q;
          if (mode_q == M_FIRST) best_q <= '0;
          else if (mode_q == M_NEWMAX) best_q <= pos_q;
          if (row_end) begin
            pos_q      <= '0;
            rec_q.sum  <= sum_n;
            rec_q.eos  <= eos_q;
            rec_q.maxv <= (mode_q != M_ADD) ? sv_q : max_q;
            rec_q.best <= (mode_q == M_FIRST) ? 13'd0 :
                          (mode_q == M_NEWMAX) ? pos_q : best_q;
            state_q    <= F_PUSH;
          end else begin
            pos_q   <= pos_q + 13'd1;
            state_q <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == F_IDLE;
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_data_o = rec_q;

endmodule

FILE: rtl/core/ctcd_back.sv
// back: drops blanks and repeats, computes probabilities and the mean
// depends on ctcd_pkg; holds one shared bit-serial divider
module ctcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_valid_i,
  input  ctcd_pkg::row_t rd_data_i,
  output logic           rd_en_o,
  input  logic [13:0]    class_count_i,
  input  logic [12:0]    blank_class_i,
  input  logic           prob_mode_i,
  input  logic [13:0]    dict_len_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_kind_o,
  output logic [12:0]    out_class_o,
  output logic           out_dict_o,
  output logic [16:0]    out_sym_o,
  output logic [16:0]    out_mean_o,
  output logic [12:0]    out_total_o,
  output logic           out_last_o
);
  import ctcd_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_SYM, B_MEAN, B_OUT} bstate_e;

  bstate_e     state_q;
  logic [12:0] prev_q;
  logic        prev_valid_q;
  logic [29:0] total_q;
  logic [12:0] count_q;
  logic [12:0] best_q;
  logic        eos_q;
  logic        pend_mean_q;
  logic        div_mean_q;
  logic [16:0] score_q;
  logic [32:0] num_q;
  logic [31:0] den_q;
  logic [33:0] rem_q;
  logic [32:0] quo_q;
  logic [5:0]  step_q;

  logic        emit;
  logic [16:0] prob;
  logic [33:0] rem_sh;
  logic        take;
  logic [33:0] rem_n;
  logic [32:0] quo_n;
  logic [30:0] tot_sum;

  always_comb begin
    emit = (class_count_i >= 14'd2) && ({1'b0, blank_class_i} < class_count_i) &&
           (rd_data_i.best != blank_class_i) &&
           !(prev_valid_q && rd_data_i.best == prev_q);
    if (rd_data_i.maxv <= 16'sd0)        prob = '0;
    else if (rd_data_i.maxv >= 16'sd4096) prob = OneQ16;
    else                                  prob = 17'(rd_data_i.maxv) << 4;
  end

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q[32:0], num_q[32]};
    take   = rem_sh >= 34'(den_q);
    rem_n  = take ? rem_sh - 34'(den_q) : rem_sh;
    quo_n  = {quo_q[31:0], take};
    tot_sum = 31'(total_q) + 31'(score_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      total_q      <= '0;
      count_q      <= '0;
      pend_mean_q  <= 1'b0;
      div_mean_q   <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (rd_valid_i) begin
            best_q       <= rd_data_i.best;
            eos_q        <= rd_data_i.eos;
            prev_q       <= rd_data_i.best;
            prev_valid_q <= 1'b1;
            if (emit) begin
              if (prob_mode_i) begin
                score_q <= prob;
                state_q <= B_SYM;
              end else begin
                num_q      <= {1'b1, 32'd0} + 33'(rd_data_i.sum >> 1);
                den_q      <= rd_data_i.sum;
                rem_q      <= '0;
                step_q     <= '0;
                div_mean_q <= 1'b0;
                state_q    <= B_DIV;
              end
            end else if (rd_data_i.eos) begin
              state_q <= B_MEAN;
            end
          end
        end
        B_DIV: begin
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          num_q  <= {num_q[31:0], 1'b0};
          step_q <= step_q + 6'd1;
          if (step_q == 6'd32) begin
            if (div_mean_q) begin
              out_kind_o  <= KindMean;
              out_class_o <= '0;
              out_dict_o  <= 1'b0;
              out_sym_o   <= '0;
              out_mean_o  <= quo_n[16:0];
              out_total_o <= count_q;
              out_last_o  <= 1'b1;
              out_valid_o <= 1'b1;
              state_q     <= B_OUT;
            end else begin
              score_q <= (quo_n > 33'(OneQ16)) ? OneQ16 : quo_n[16:0];
              state_q <= B_SYM;
            end
          end
        end
        B_SYM: begin
          out_kind_o  <= KindSymbol;
          out_class_o <= best_q;
          out_dict_o  <= (best_q >= 13'd1) && ({1'b0, best_q} <= dict_len_i);
          out_sym_o   <= score_q;
          out_mean_o  <= '0;
          out_last_o  <= !eos_q;
          out_valid_o <= 1'b1;
          pend_mean_q <= eos_q;
          if (count_q < 13'(MaxTimeSteps)) begin
            count_q     <= count_q + 13'd1;
            out_total_o <= count_q + 13'd1;
            total_q     <= (tot_sum > 31'(TotalMax)) ? TotalMax : tot_sum[29:0];
          end else begin
            out_total_o <= count_q;
          end
          state_q <= B_OUT;
        end
        B_MEAN: begin
          if (count_q == 13'd0) begin
            out_kind_o  <= KindMean;
            out_class_o <= '0;
            out_dict_o  <= 1'b0;
            out_sym_o   <= '0;
            out_mean_o  <= '0;
            out_total_o <= '0;
            out_last_o  <= 1'b1;
            out_valid_o <= 1'b1;
            state_q     <= B_OUT;
          end else begin
            num_q      <= 33'(total_q) + 33'(count_q >> 1);
            den_q      <= 32'(count_q);
            rem_q      <= '0;
            step_q     <= '0;
            div_mean_q <= 1'b1;
            state_q    <= B_DIV;
          end
        end
        B_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (pend_mean_q) begin
              pend_mean_q <= 1'b0;
              state_q     <= B_MEAN;
            end else begin
              if (out_kind_o == KindMean) begin
                prev_q       <= '0;
                prev_valid_q <= 1'b0;
                total_q      <= '0;
                count_q      <= '0;
              end
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign rd_en_o = (state_q == B_IDLE) && rd_valid_i;

endmodule

FILE: rtl/core/ctc_greedy_decoder.sv
// top level of the ctc greedy decoder
// depends on ctcd_pkg, ctcd_front, ctcd_fifo and ctcd_back
//
// Scores stream in one per transaction on the slave side, row after row, each
// row holding class_count scores (1 when zero, at most 8192); tlast marks the
// last score of a sequence and may cut the final row short. The front keeps
// the first maximum of the row and a q16.16 running sum of exp(x - max) that
// is rescaled whenever a new maximum arrives. Each score passes in turn
// through accept, exponent multiply, table lookup with shift, rescale
// multiply and update in the front, and at row end the row is handed to a
// two-entry queue (waiting while the queue is full).
// The back drops the blank and repeats of the previous row's class, and
// emits a symbol with probability round(2^32/sum) in logit mode or the row
// maximum, clipped to 0..4096 and shifted left by four, in probability mode.
// Its 33-step bit-serial divider serves the logit-mode symbol and the mean,
// and the back takes no new row until it is through with the last one and
// its output; the mean score follows at sequence end, with no division when
// no symbol was counted. A symbol result comes before the mean result; all
// sequence state clears after the mean is taken.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i by the
// user only while the block is idle; the block itself does not enforce this.
module ctc_greedy_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // score_value
  input  logic        s_axis_tlast,   // end_of_sequence
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // class_index[12:0], in_dictionary[13], symbol_score[30:14],
  // mean_score[47:31], symbol_total[60:48], zero fill [63:61]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);
  import ctcd_pkg::*;

  logic [13:0] class_count_q;
  logic [12:0] blank_class_q;
  logic        prob_mode_q;
  logic [13:0] dict_len_q;

  logic        push, full, pop, rd_valid;
  row_t        push_data, rd_data;

  logic        kind, dict, last;
  logic [12:0] cls, total;
  logic [16:0] sym, mean;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= 14'd2;
      blank_class_q <= '0;
      prob_mode_q   <= 1'b0;
      dict_len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegClassCount: class_count_q <= cfg_data_i;
        RegBlank:      blank_class_q <= cfg_data_i[12:0];
        RegProbMode:   prob_mode_q   <= cfg_data_i[0];
        RegDictSize:   dict_len_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // row statistics
  ctcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_score_i    (s_axis_tdata),
    .in_eos_i      (s_axis_tlast),
    .class_count_i (class_count_q),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  // finished rows wait here so front and back stall independently
  ctcd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (push_data),
    .full_o     (full),
    .rd_en_i    (pop),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid)
  );

  // symbol decision, probabilities and mean
  ctcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_valid_i    (rd_valid),
    .rd_data_i     (rd_data),
    .rd_en_o       (pop),
    .class_count_i (class_count_q),
    .blank_class_i (blank_class_q),
    .prob_mode_i   (prob_mode_q),
    .dict_len_i    (dict_len_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (kind),
    .out_class_o   (cls),
    .out_dict_o    (dict),
    .out_sym_o     (sym),
    .out_mean_o    (mean),
    .out_total_o   (total),
    .out_last_o    (last)
  );

  assign m_axis_tdata = {3'b000, total, mean, sym, dict, cls};
  assign m_axis_tuser = kind;
  assign m_axis_tlast = last;

endmodule

FILE: tb/testbench.sv
// self-checking testbench of the ctc greedy decoder
// streams score rows, predicts symbol and mean results, compares every result transaction
// depends on ctcd_pkg and the ctc_greedy_decoder rtl
`timescale 1ns / 1ps

module testbench;
  import ctcd_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [12:0] cls;
    logic        dict;
    logic [16:0] sym;
    logic [16:0] mean;
    logic [12:0] total;
    logic        last;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  ctc_greedy_decoder uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the configuration
  logic [13:0] n_classes;
  logic [12:0] blank_idx;
  logic        prob_mode;
  logic [13:0] dict_entries;
  // predictor copy of the sequence state
  logic [12:0]        col;
  logic signed [15:0] row_max;
  logic [12:0]        row_best;
  logic [31:0]        sum_q16;
  logic [12:0]        prev_cls;
  logic               prev_ok;
  logic [29:0]        prob_total;
  logic [12:0]        sym_count;
  logic [16:0]        exp_lut [ExpDepth];

  decoded_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0; // no idling in the final phase

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // 2^(-i/ExpDepth) series table, built independently with 64-bit arithmetic
  function automatic void fill_exp_lut();
    longint unsigned z, term;
    longint acc;
    for (int i = 0; i < ExpDepth; i++) begin
      z = (longint'(i) * 64'd2977044472) / ExpDepth;
      term = 64'd1 << 32;
      acc = longint'(term);
      for (int n = 1; n <= 14; n++) begin
        term = ((term * z) >> 32) / n;
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      exp_lut[i] = 17'((unsigned'(acc) + 32768) >> 16);
    end
  endfunction

  function automatic logic [31:0] exp_decay(input logic [31:0] d);
    longint unsigned e, k, idx;
    e = longint'(d) * 94548;
    k = e >> 28;
    idx = ((e & ((64'd1 << 28) - 1)) * ExpDepth) >> 28;
    if (k >= 32 || idx >= ExpDepth) return 0;
    return 32'(exp_lut[idx]) >> k;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_sequence();
    col = 0; row_max = 0; row_best = 0; sum_q16 = 0;
    prev_cls = 0; prev_ok = 0; prob_total = 0; sym_count = 0;
  endfunction

  // predict the results caused by one accepted score
  function automatic void decode_score(input logic signed [15:0] sv, input logic eos);
    int unsigned row_len;
    decoded_t r;
    logic [16:0] p;
    longint unsigned q, t;
    bit emit;
    row_len = n_classes < 1 ? 1 : (n_classes > MaxClasses ? MaxClasses : n_classes);
    if (col == 0) begin
      row_max = sv; row_best = 0; sum_q16 = 32'd65536;
    end else if (sv > row_max) begin
      q = (longint'(sum_q16) * exp_decay(32'(sv - row_max)) + 32768) >> 16;
      sum_q16 = add_sat(32'(q), 32'd65536);
      row_max = sv; row_best = col;
    end else begin
      sum_q16 = add_sat(sum_q16, exp_decay(32'(row_max - sv)));
    end
    if (eos || col + 1 >= row_len) begin
      col = 0;
      emit = n_classes >= 2 && blank_idx < n_classes && row_best != blank_idx &&
             !(prev_ok && row_best == prev_cls);
      if (emit) begin
        if (prob_mode) begin
          p = row_max <= 0 ? 17'd0 : (row_max >= 4096 ? 17'd65536 : 17'(row_max) << 4);
        end else begin
          q = ((64'd1 << 32) + sum_q16 / 2) / sum_q16;
          p = q > 65536 ? 17'd65536 : 17'(q);
        end
        if (sym_count < MaxTimeSteps) begin
          t = prob_total + p;
          sym_count++;
          prob_total = t > 30'h3FFF_FFFF ? 30'h3FFF_FFFF : 30'(t);
        end
        r = '0;
        r.kind = KindSymbol; r.cls = row_best; r.sym = p; r.total = sym_count;
        r.dict = row_best >= 1 && row_best <= dict_entries;
        r.last = !eos;
        expected_results.insert(expected_results.size(), r);
      end
      prev_cls = row_best; prev_ok = 1;
      if (eos) begin
        r = '0;
        r.kind = KindMean; r.total = sym_count; r.last = 1;
        if (sym_count > 0) r.mean = 17'((longint'(prob_total) + sym_count / 2) / sym_count);
        expected_results.insert(expected_results.size(), r);
        clear_sequence();
      end
    end else begin
      col++;
    end
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    decoded_t w;
    decoded_t g;
    if (m_axis_tvalid && m_axis_tready) begin
      g.kind = m_axis_tuser; g.cls = m_axis_tdata[12:0]; g.dict = m_axis_tdata[13];
      g.sym = m_axis_tdata[30:14]; g.mean = m_axis_tdata[47:31];
      g.total = m_axis_tdata[60:48]; g.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        report("unexpected result", g, 0);
      end else begin
        w = expected_results.pop_front();
        if (g.kind !== w.kind) report("result_kind", g.kind, w.kind);
        if (g.cls !== w.cls) report("class_index", g.cls, w.cls);
        if (g.dict !== w.dict) report("in_dictionary", g.dict, w.dict);
        if (g.sym !== w.sym) report("symbol_score", g.sym, w.sym);
        if (g.mean !== w.mean) report("mean_score", g.mean, w.mean);
        if (g.total !== w.total) report("symbol_total", g.total, w.total);
        if (g.last !== w.last) report("last_result", g.last, w.last);
      end
    end
    // stall bursts of random length
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= (stall_left == 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // write enable stays high across back-to-back writes, configure drops it
  task automatic write_reg(input logic [1:0] idx, input logic [13:0] value);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      RegClassCount: n_classes = value;
      RegBlank:      blank_idx = value[12:0];
      RegProbMode:   prob_mode = value[0];
      default:       dict_entries = value;
    endcase
  endtask

  // stop sending and wait until every predicted result has arrived, plus a margin
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic configure(input logic [13:0] cc, input logic [13:0] bl,
                           input logic pm, input logic [13:0] ds);
    drain();
    write_reg(RegClassCount, cc);
    write_reg(RegBlank, bl);
    write_reg(RegProbMode, {13'd0, pm});
    write_reg(RegDictSize, ds);
    cfg_we_i <= 1'b0;
  endtask

  // send one score; random sender gaps before it, tvalid stays up for the next one
  task automatic send_score(input logic [15:0] sv, input logic eos);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tdata <= sv; s_axis_tlast <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_score(sv, eos);
  endtask

  // one sequence of rows; random scores, mostly within -6000..6000, sometimes any 16-bit value
  task automatic send_sequence(input int rows, input int cut);
    int row_len;
    row_len = n_classes < 2 ? 1 : n_classes;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < row_len; c++) begin
        logic last_one;
        last_one = (r == rows - 1) && (c == row_len - 1 || c == cut);
        send_score($urandom_range(0, 3) == 0 ? 16'($urandom) :
                   16'($urandom_range(0, 12000) - 6000), last_one);
        if (last_one) return;
      end
  endtask

  task automatic test_extremes();
    configure(14'd4, 14'd0, 1'b0, 14'd2);
    send_score(16'h7FFF, 0); send_score(16'h8000, 0); send_score(16'h0000, 0);
    send_score(16'h7FFF, 0);              // tie keeps first maximum, class 0 is blank
    send_score(16'h8000, 0); send_score(16'h7FFF, 0); send_score(16'h0001, 0);
    send_score(16'hFFFF, 0);              // class 1
    send_score(16'h8000, 0); send_score(16'h7FFF, 0); send_score(16'h0, 0);
    send_score(16'h0, 0);                 // repeat of class 1 dropped
    send_score(16'h0, 0); send_score(16'h0, 0); send_score(16'h1000, 1); // early end
    send_score(16'h1234, 1);              // empty sequence, mean zero
  endtask

  task automatic test_probability_mode();
    configure(14'd3, 14'd2, 1'b1, 14'd1);
    send_score(16'hF000, 0); send_score(16'h0800, 0); send_score(16'h0, 0);
    send_score(16'h0, 0); send_score(16'h0, 0); send_score(16'h4000, 0); // maximum on the blank, dropped
    send_score(16'hFFF0, 0); send_score(16'hFFFF, 1);                    // negative max
  endtask

  task automatic test_short_rows_and_blank();
    configure(14'd1, 14'd0, 1'b0, 14'd0);     // row of one, all suppressed
    send_sequence(3, -1);
    configure(14'd0, 14'd0, 1'b1, 14'd0);
    send_sequence(2, -1);
    configure(14'd5, 14'd9, 1'b0, 14'd8192);  // blank out of range
    send_sequence(4, -1);
    configure(14'd2, 14'd1, 1'b1, 14'd8191);
    send_sequence(6, -1);
  endtask

  task automatic test_random(input int n_seq);
    for (int i = 0; i < n_seq; i++) begin
      if (i % 8 == 0)
        configure(14'($urandom_range(2, 12)), 14'($urandom_range(0, 13)),
                  1'($urandom), 14'($urandom_range(0, 14)));
      if (i == n_seq / 2) drain(); // sender holds until all results are in
      send_sequence($urandom_range(1, 8),
                    $urandom_range(0, 4) == 0 ? $urandom_range(0, 10) : -1);
    end
  endtask

  task automatic test_large_rows();
    configure(14'd16383, 14'd8191, 1'b0, 14'd16383); // clamped to the largest row
    send_sequence(1, 30);
    configure(14'd8192, 14'd5, 1'b1, 14'd3);
    send_sequence(1, 20);
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    configure(14'd3, 14'd0, 1'b0, 14'd2);
    for (int i = 0; i < 8; i++) send_sequence($urandom_range(1, 5), -1);
  endtask

  initial begin
    fill_exp_lut();
    n_classes = 2; blank_idx = 0; prob_mode = 0; dict_entries = 0;
    clear_sequence();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_probability_mode();
    test_short_rows_and_blank();
    test_random(20);
    test_large_rows();
    test_quiet_tail();
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ctcd_pkg.sv
rtl/core/ctcd_fifo.sv
rtl/core/ctcd_front.sv
rtl/core/ctcd_back.sv
rtl/core/ctc_greedy_decoder.sv
tb/testbench.sv
